// File: design/euler_cfl_timestep_min_core_macros.svh
// Assertion macros used by the controller RTL file.
`ifndef EULER_CFL_TIMESTEP_MIN_CORE_MACROS_SVH
`define EULER_CFL_TIMESTEP_MIN_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define ECFL_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ecfl: same-cycle check failed");
`define ECFL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ecfl: next-cycle check failed");
`else
`define ECFL_ASSERT_IMPLY(lbl, ante, cons)
`define ECFL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: design/ecfl_pkg.sv
package ecfl_pkg;

  // Configuration register indexes and reset values
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 31;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAMMA   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_X  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_Y  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_COURANT = 2'd3;

  localparam logic [17:0] GAMMA_RESET   = 18'd91750;
  localparam logic [30:0] SIZE_RESET    = 31'd65536;
  localparam logic [16:0] COURANT_RESET = 17'd58982;
  localparam logic [17:0] GAMMA_ONE     = 18'd65536;

  // Shared divider sizes: widest dividend is (|u|+c) << 32
  localparam int DIV_W      = 81;
  localparam int DIVISOR_W  = 64;
  localparam int DIV_CNT_W  = 7;

  localparam logic [63:0] SAT64 = '1;
  localparam logic [31:0] SAT32 = '1;

  typedef struct packed {
    logic [30:0] density;
    logic signed [31:0] momentum_x;
    logic signed [31:0] momentum_y;
    logic [30:0] total_energy;
    logic last_cell;
  } ecfl_in_t;

  typedef struct packed {
    logic [31:0] dt_estimate;
    logic pressure_clamped;
  } ecfl_out_t;

  typedef enum logic [2:0] {
    MUL_AX, MUL_AY, MUL_P, MUL_GP, MUL_EST
  } mul_op_t;

  typedef enum logic [2:0] {
    DIV_SU, DIV_SV, DIV_KE, DIV_C2, DIV_RX, DIV_RY, DIV_DT
  } div_op_t;

  typedef struct packed {
    logic    load_in;
    logic    mul_en;
    mul_op_t mul_op;
    logic    div_start;
    logic    div_capture;
    div_op_t div_op;
    logic    sqr_load;
    logic    sqr_acc;
    logic    p_load;
    logic    sqrt_start;
    logic    sqrt_capture;
    logic    min_update;
    logic    emit;
  } ecfl_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic sqrt_busy;
    logic sqrt_done;
    logic last_cell;
  } ecfl_status_t;

endpackage

// File: design/ecfl_div.sv
module ecfl_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [ecfl_pkg::DIV_W-1:0]           dividend,
  input  logic [ecfl_pkg::DIVISOR_W-1:0]       divisor,
  input  logic [ecfl_pkg::DIV_CNT_W-1:0]       bits,
  output logic [ecfl_pkg::DIV_W-1:0]           quotient,
  output logic                                 busy,
  output logic                                 done
);

  logic [ecfl_pkg::DIV_W-1:0]     quo;
  logic [ecfl_pkg::DIVISOR_W-1:0] rem;
  logic [ecfl_pkg::DIVISOR_W-1:0] dvs;
  logic [ecfl_pkg::DIV_CNT_W-1:0] cnt;
  logic [ecfl_pkg::DIVISOR_W:0]   trial;
  logic [ecfl_pkg::DIVISOR_W:0]   diff;
  logic                           ge;

  // One restoring step: bring down the next dividend bit, try the subtract
  always_comb begin
    trial = {rem, quo[ecfl_pkg::DIV_W-1]};
    diff  = trial - {1'b0, dvs};
    ge    = trial >= {1'b0, dvs};
  end

  // Dividend is left-aligned, so quotient bits fill the low end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
        cnt  <= bits;
        busy <= 1'b1;
      end else if (busy) begin
        quo <= {quo[ecfl_pkg::DIV_W-2:0], ge};
        rem <= ge ? diff[ecfl_pkg::DIVISOR_W-1:0] : trial[ecfl_pkg::DIVISOR_W-1:0];
        cnt <= cnt - 1'b1;
        if (cnt == ecfl_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// File: design/ecfl_sqrt.sv
module ecfl_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic [31:0] root,
  output logic        busy,
  output logic        done
);

  logic [63:0] x;
  logic [31:0] root_r;
  logic [33:0] rem;
  logic [5:0]  cnt;
  logic [35:0] rem2;
  logic [35:0] trial;
  logic        ge;

  // One digit: two radicand bits in, one root bit out
  always_comb begin
    rem2  = {rem, x[63:62]};
    trial = {2'b00, root_r, 2'b01};
    ge    = rem2 >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x      <= radicand;
        root_r <= '0;
        rem    <= '0;
        cnt    <= 6'd32;
        busy   <= 1'b1;
      end else if (busy) begin
        x      <= {x[61:0], 2'b00};
        root_r <= {root_r[30:0], ge};
        rem    <= ge ? 34'(rem2 - trial) : rem2[33:0];
        cnt    <= cnt - 1'b1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = root_r;

endmodule

// File: design/ecfl_datapath.sv
module ecfl_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [ecfl_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [ecfl_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  ecfl_pkg::ecfl_in_t                     in_item,
  input  ecfl_pkg::ecfl_cmd_t                    cmd,
  output ecfl_pkg::ecfl_status_t                 status,
  output ecfl_pkg::ecfl_out_t                    out_item
);

  // Configuration
  logic [17:0] gamma;
  logic [30:0] size_x;
  logic [30:0] size_y;
  logic [16:0] courant;

  // Cell operands and intermediates
  logic [30:0] rho;
  logic [31:0] amx;
  logic [31:0] amy;
  logic [30:0] energy;
  logic        last;
  logic [47:0] su;
  logic [47:0] sv;
  logic [63:0] sqr;
  logic [63:0] ke;
  logic [32:0] p;
  logic        flag;
  logic [63:0] c2;
  logic [31:0] c;
  logic [63:0] rate_x;
  logic [63:0] rate;
  logic [31:0] dt;
  logic [65:0] prod;

  // Reduction state
  logic [31:0] minimum;
  logic        clamp;

  logic [32:0] mul_a;
  logic [32:0] mul_b;
  logic        p_ok;
  logic [17:0] gm1;
  logic [30:0] ediff;
  logic [30:0] dx;
  logic [30:0] dy;
  logic [48:0] sum_x;
  logic [48:0] sum_y;

  logic [ecfl_pkg::DIV_W-1:0]     dvd;
  logic [ecfl_pkg::DIVISOR_W-1:0] dvs;
  logic [ecfl_pkg::DIV_CNT_W-1:0] dbits;
  logic [ecfl_pkg::DIV_W-1:0]     quo;
  logic [63:0]                    qsat;
  logic [64:0]                    rsum;
  logic [31:0]                    root;
  logic                           div_busy;
  logic                           div_done;
  logic                           sqrt_busy;
  logic                           sqrt_done;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gamma   <= ecfl_pkg::GAMMA_RESET;
      size_x  <= ecfl_pkg::SIZE_RESET;
      size_y  <= ecfl_pkg::SIZE_RESET;
      courant <= ecfl_pkg::COURANT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        ecfl_pkg::CFG_GAMMA:   gamma   <= cfg_data[17:0];
        ecfl_pkg::CFG_SIZE_X:  size_x  <= cfg_data;
        ecfl_pkg::CFG_SIZE_Y:  size_y  <= cfg_data;
        ecfl_pkg::CFG_COURANT: courant <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // Zero cell size acts as the smallest step
  assign dx = (size_x == '0) ? 31'd1 : size_x;
  assign dy = (size_y == '0) ? 31'd1 : size_y;

  // Pressure exists only above the kinetic energy and for gamma over one
  always_comb begin
    p_ok  = ({33'd0, energy} > ke) && (gamma > ecfl_pkg::GAMMA_ONE);
    gm1   = p_ok ? (gamma - ecfl_pkg::GAMMA_ONE) : 18'd0;
    ediff = p_ok ? (energy - ke[30:0]) : 31'd0;
    sum_x = {1'b0, su} + {17'd0, c};
    sum_y = {1'b0, sv} + {17'd0, c};
  end

  // Multiplier operand select
  always_comb begin
    case (cmd.mul_op)
      ecfl_pkg::MUL_AX: begin
        mul_a = {1'b0, amx};
        mul_b = {1'b0, amx};
      end
      ecfl_pkg::MUL_AY: begin
        mul_a = {1'b0, amy};
        mul_b = {1'b0, amy};
      end
      ecfl_pkg::MUL_P: begin
        mul_a = {15'd0, gm1};
        mul_b = {2'd0, ediff};
      end
      ecfl_pkg::MUL_GP: begin
        mul_a = {15'd0, gamma};
        mul_b = p;
      end
      ecfl_pkg::MUL_EST: begin
        mul_a = {1'b0, minimum};
        mul_b = {16'd0, courant};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Divider operand select, dividend left-aligned to its bit count
  always_comb begin
    case (cmd.div_op)
      ecfl_pkg::DIV_SU: begin
        dvd   = {amx, 49'd0};
        dvs   = {33'd0, rho};
        dbits = 7'd48;
      end
      ecfl_pkg::DIV_SV: begin
        dvd   = {amy, 49'd0};
        dvs   = {33'd0, rho};
        dbits = 7'd48;
      end
      ecfl_pkg::DIV_KE: begin
        dvd   = {sqr, 17'd0};
        dvs   = {33'd0, rho};
        dbits = 7'd64;
      end
      ecfl_pkg::DIV_C2: begin
        dvd   = {prod[50:0], 30'd0};
        dvs   = {33'd0, rho};
        dbits = 7'd67;
      end
      ecfl_pkg::DIV_RX: begin
        dvd   = {sum_x, 32'd0};
        dvs   = {33'd0, dx};
        dbits = 7'd81;
      end
      ecfl_pkg::DIV_RY: begin
        dvd   = {sum_y, 32'd0};
        dvs   = {33'd0, dy};
        dbits = 7'd81;
      end
      ecfl_pkg::DIV_DT: begin
        dvd   = {1'b1, 80'd0};
        dvs   = rate;
        dbits = 7'd57;
      end
      default: begin
        dvd   = '0;
        dvs   = '0;
        dbits = '0;
      end
    endcase
  end

  ecfl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .bits     (dbits),
    .quotient (quo),
    .busy     (div_busy),
    .done     (div_done)
  );

  ecfl_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (c2),
    .root     (root),
    .busy     (sqrt_busy),
    .done     (sqrt_done)
  );

  // Saturate the Q32.32 rate quotients; add the two rates with saturation
  always_comb begin
    qsat = (quo[80:64] != '0) ? ecfl_pkg::SAT64 : quo[63:0];
    rsum = {1'b0, rate_x} + {1'b0, qsat};
  end

  // Operand capture and intermediate results
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      rho    <= (in_item.density == '0) ? 31'd1 : in_item.density;
      amx    <= in_item.momentum_x[31] ? 32'(-in_item.momentum_x) : in_item.momentum_x;
      amy    <= in_item.momentum_y[31] ? 32'(-in_item.momentum_y) : in_item.momentum_y;
      energy <= in_item.total_energy;
      last   <= in_item.last_cell;
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.sqr_load) begin
      sqr <= prod[63:0];
    end else if (cmd.sqr_acc) begin
      sqr <= sqr + prod[63:0];
    end
    if (cmd.p_load) begin
      p    <= prod[48:16];
      flag <= (prod[48:16] == '0);
    end
    if (cmd.sqrt_capture) begin
      c <= root;
    end
    if (cmd.div_capture) begin
      case (cmd.div_op)
        ecfl_pkg::DIV_SU: su <= quo[47:0];
        ecfl_pkg::DIV_SV: sv <= quo[47:0];
        ecfl_pkg::DIV_KE: ke <= {1'b0, quo[63:1]};
        ecfl_pkg::DIV_C2: c2 <= (quo[66:64] != '0) ? ecfl_pkg::SAT64 : quo[63:0];
        ecfl_pkg::DIV_RX: rate_x <= qsat;
        ecfl_pkg::DIV_RY: rate <= rsum[64] ? ecfl_pkg::SAT64 : rsum[63:0];
        ecfl_pkg::DIV_DT: dt <= (quo[56:32] != '0) ? ecfl_pkg::SAT32 : quo[31:0];
        default: ;
      endcase
    end
  end

  // Running minimum and clamp flag; clear after a result
  always_ff @(posedge clk) begin
    if (rst) begin
      minimum <= ecfl_pkg::SAT32;
      clamp   <= 1'b0;
    end else if (cmd.emit) begin
      minimum <= ecfl_pkg::SAT32;
      clamp   <= 1'b0;
    end else if (cmd.min_update) begin
      if (dt < minimum) begin
        minimum <= dt;
      end
      if (flag) begin
        clamp <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item.dt_estimate      <= prod[48] ? ecfl_pkg::SAT32 : prod[47:16];
      out_item.pressure_clamped <= clamp;
    end
  end

  assign status.div_busy  = div_busy;
  assign status.div_done  = div_done;
  assign status.sqrt_busy = sqrt_busy;
  assign status.sqrt_done = sqrt_done;
  assign status.last_cell = last;

endmodule

// File: design/ecfl_ctrl.sv
`include "euler_cfl_timestep_min_core_macros.svh"

module ecfl_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  ecfl_pkg::ecfl_status_t status,
  output ecfl_pkg::ecfl_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_SU_GO, S_SU_WAIT, S_SV_GO, S_SV_WAIT,
    S_MX, S_MY, S_SUM, S_KE_GO, S_KE_WAIT,
    S_MP, S_PCAP, S_MGP, S_C2_GO, S_C2_WAIT,
    S_SQ_GO, S_SQ_WAIT, S_RX_GO, S_RX_WAIT, S_RY_GO, S_RY_WAIT,
    S_DT_GO, S_DT_WAIT, S_UPD, S_MEST, S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   emit_fire;

  assign in_ready  = (state == S_IDLE);
  assign emit_fire = (state == S_EMIT) && (!out_valid || out_ready);

  // Sequence the per-cell work; each wait state holds until its unit is done
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_next = S_SU_GO;
        end
      end
      S_SU_GO: begin
        cmd.div_op    = ecfl_pkg::DIV_SU;
        cmd.div_start = 1'b1;
        state_next    = S_SU_WAIT;
      end
      S_SU_WAIT: begin
        cmd.div_op      = ecfl_pkg::DIV_SU;
        cmd.div_capture = status.div_done;
        if (status.div_done) begin
          state_next = S_SV_GO;
        end
      end
      S_SV_GO: begin
        cmd.div_op    = ecfl_pkg::DIV_SV;
        cmd.div_start = 1'b1;
        state_next    = S_SV_WAIT;
      end
      S_SV_WAIT: begin
        cmd.div_op      = ecfl_pkg::DIV_SV;
        cmd.div_capture = status.div_done;
        if (status.div_done) begin
          state_next = S_MX;
        end
      end
      S_MX: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = ecfl_pkg::MUL_AX;
        state_next = S_MY;
      end
      S_MY: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_op   = ecfl_pkg::MUL_AY;
        cmd.sqr_load = 1'b1;
        state_next   = S_SUM;
      end
      S_SUM: begin
        cmd.sqr_acc = 1'b1;
        state_next  = S_KE_GO;
      end
      S_KE_GO: begin
        cmd.div_op    = ecfl_pkg::DIV_KE;
        cmd.div_start = 1'b1;
        state_next    = S_KE_WAIT;
      end
      S_KE_WAIT: begin
        cmd.div_op      = ecfl_pkg::DIV_KE;
        cmd.div_capture = status.div_done;
        if (status.div_done) begin
          state_next = S_MP;
        end
      end
      S_MP: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = ecfl_pkg::MUL_P;
        state_next = S_PCAP;
      end
      S_PCAP: begin
        cmd.p_load = 1'b1;
        state_next = S_MGP;
      end
      S_MGP: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = ecfl_pkg::MUL_GP;
        state_next = S_C2_GO;
      end
      S_C2_GO: begin
        cmd.div_op    = ecfl_pkg::DIV_C2;
        cmd.div_start = 1'b1;
        state_next    = S_C2_WAIT;
      end
      S_C2_WAIT: begin
        cmd.div_op      = ecfl_pkg::DIV_C2;
        cmd.div_capture = status.div_done;
        if (status.div_done) begin
          state_next = S_SQ_GO;
        end
      end
      S_SQ_GO: begin
        cmd.sqrt_start = 1'b1;
        state_next     = S_SQ_WAIT;
      end
      S_SQ_WAIT: begin
        cmd.sqrt_capture = status.sqrt_done;
        if (status.sqrt_done) begin
          state_next = S_RX_GO;
        end
      end
      S_RX_GO: begin
        cmd.div_op    = ecfl_pkg::DIV_RX;
        cmd.div_start = 1'b1;
        state_next    = S_RX_WAIT;
      end
      S_RX_WAIT: begin
        cmd.div_op      = ecfl_pkg::DIV_RX;
        cmd.div_capture = status.div_done;
        if (status.div_done) begin
          state_next = S_RY_GO;
        end
      end
      S_RY_GO: begin
        cmd.div_op    = ecfl_pkg::DIV_RY;
        cmd.div_start = 1'b1;
        state_next    = S_RY_WAIT;
      end
      S_RY_WAIT: begin
        cmd.div_op      = ecfl_pkg::DIV_RY;
        cmd.div_capture = status.div_done;
        if (status.div_done) begin
          state_next = S_DT_GO;
        end
      end
      S_DT_GO: begin
        cmd.div_op    = ecfl_pkg::DIV_DT;
        cmd.div_start = 1'b1;
        state_next    = S_DT_WAIT;
      end
      S_DT_WAIT: begin
        // A zero rate yields an all-ones quotient, which saturates as required
        cmd.div_op      = ecfl_pkg::DIV_DT;
        cmd.div_capture = status.div_done;
        if (status.div_done) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.min_update = 1'b1;
        state_next     = status.last_cell ? S_MEST : S_IDLE;
      end
      S_MEST: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = ecfl_pkg::MUL_EST;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        // Hold until the output register is free
        cmd.emit = emit_fire;
        if (emit_fire) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ECFL_ASSERT_IMPLY(a_div_start_idle, cmd.div_start, !status.div_busy)
  `ECFL_ASSERT_IMPLY(a_sqrt_start_idle, cmd.sqrt_start, !status.sqrt_busy)
  `ECFL_ASSERT_IMPLY(a_ready_units_idle, in_ready, !status.div_busy && !status.sqrt_busy)
  `ECFL_ASSERT_NEXT(a_emit_sets_valid, emit_fire, out_valid)

endmodule

// File: design/euler_cfl_timestep_min_core.sv
// Channel   Signals                             Moves
// input     in_valid, in_ready, in_item         one cell per item
// output    out_valid, out_ready, out_item      dt estimate, on a last cell
// config    cfg_write, cfg_index, cfg_data      register write, no wait
//
// One item at a time: a cell is taken only in the idle state, and a last cell
// may also wait for out_ready. The time per cell is set by the single shared
// radix-2 divider (seven divisions, 446 quotient bits) and the 32-step square
// root unit. Reset is synchronous and restores the configuration defaults
// and an empty reduction. A result waiting in the output register does not
// stop the next cell; only its own emit step waits for the register to drain.
module euler_cfl_timestep_min_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  ecfl_pkg::ecfl_in_t                 in_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output ecfl_pkg::ecfl_out_t                out_item,
  input  logic                               cfg_write,
  input  logic [ecfl_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ecfl_pkg::CFG_DATA_W-1:0]    cfg_data
);

  ecfl_pkg::ecfl_cmd_t    cmd;
  ecfl_pkg::ecfl_status_t status;

  ecfl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ecfl_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_item  (out_item)
  );

endmodule

// File: sim/euler_cfl_timestep_min_core_test.sv
module euler_cfl_timestep_min_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 600;
  localparam int STALL_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  ecfl_pkg::ecfl_in_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ecfl_pkg::ecfl_out_t out_item;
  logic cfg_write = 1'b0;
  logic [ecfl_pkg::CFG_INDEX_W-1:0] cfg_index = ecfl_pkg::CFG_GAMMA;
  logic [ecfl_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  euler_cfl_timestep_min_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow configuration and reduction state
  logic [63:0] gamma_sh, dx_sh, dy_sh, courant_sh;
  logic [63:0] dt_min;
  bit          clamp_any;

  typedef struct {
    bit                  typed;
    ecfl_pkg::ecfl_out_t value;
  } cell_note_t;

  cell_note_t          note_q[$];
  ecfl_pkg::ecfl_out_t dt_exp_q[$];
  int          errors = 0;
  int          idle_pct = 21;
  int          hold_reqs = 0;
  int          holds_done = 0;
  int          hold_left = 0;
  int          quiet = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // floor(a * 2^sh / b), saturated
  function automatic logic [63:0] frac_div(input logic [63:0] a, input logic [63:0] b,
                                           input int sh);
    logic [63:0] q, r;
    q = a / b;
    r = a % b;
    if ((q >> (64 - sh)) != 0) return ecfl_pkg::SAT64;
    return (q << sh) + ((r << sh) / b);
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] mag32(input logic [31:0] m);
    logic [31:0] n;
    n = -m;
    return m[31] ? {32'd0, n} : {32'd0, m};
  endfunction

  // Advance the reduction by one cell; returns 1 when a dt estimate is due
  function automatic bit step_cfl(input ecfl_pkg::ecfl_in_t c,
                                  output ecfl_pkg::ecfl_out_t est);
    logic [63:0] rho, amx, amy, en, dx, dy, su, sv, ke, p, c2, cs, rx, ry, rate, dt, prod;
    rho = {33'd0, c.density};
    if (rho == 0) rho = 1;
    amx = mag32(c.momentum_x);
    amy = mag32(c.momentum_y);
    en = {33'd0, c.total_energy};
    dx = (dx_sh == 0) ? 64'd1 : dx_sh;
    dy = (dy_sh == 0) ? 64'd1 : dy_sh;
    su = frac_div(amx, rho, 16);
    sv = frac_div(amy, rho, 16);
    ke = ((amx * amx + amy * amy) / rho) >> 1;
    p = 0;
    if (en > ke && gamma_sh > 65536) p = ((gamma_sh - 65536) * (en - ke)) >> 16;
    c2 = frac_div(gamma_sh * p, rho, 16);
    cs = root_floor(c2);
    rx = frac_div(su + cs, dx, 32);
    ry = frac_div(sv + cs, dy, 32);
    rate = (rx > ecfl_pkg::SAT64 - ry) ? ecfl_pkg::SAT64 : rx + ry;
    if (rate == 0) dt = {32'd0, ecfl_pkg::SAT32};
    else begin
      dt = (64'd1 << 56) / rate;
      if (dt > {32'd0, ecfl_pkg::SAT32}) dt = {32'd0, ecfl_pkg::SAT32};
    end
    if (dt < dt_min) dt_min = dt;
    if (p == 0) clamp_any = 1'b1;
    est = '0;
    if (!c.last_cell) return 1'b0;
    prod = (dt_min * courant_sh) >> 16;
    est.dt_estimate = (prod > {32'd0, ecfl_pkg::SAT32}) ? ecfl_pkg::SAT32 : prod[31:0];
    est.pressure_clamped = clamp_any;
    dt_min = {32'd0, ecfl_pkg::SAT32};
    clamp_any = 1'b0;
    return 1'b1;
  endfunction

  // Predict on every accepted cell
  always @(posedge clk) begin
    cell_note_t          n;
    ecfl_pkg::ecfl_out_t est;
    if (!rst && in_valid && in_ready) begin
      n = note_q.pop_front();
      if (step_cfl(in_item, est)) dt_exp_q.push_back(n.typed ? n.value : est);
    end
  end

  // Compare every accepted result with the oldest expectation
  always @(posedge clk) begin
    ecfl_pkg::ecfl_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (dt_exp_q.size() == 0) begin
        report("unexpected result", out_item.dt_estimate, 0);
      end else begin
        want = dt_exp_q.pop_front();
        if (out_item.dt_estimate !== want.dt_estimate)
          report("dt_estimate", out_item.dt_estimate, want.dt_estimate);
        if (out_item.pressure_clamped !== want.pressure_clamped)
          report("pressure_clamped", out_item.pressure_clamped, want.pressure_clamped);
      end
    end
  end

  // Receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done < hold_reqs) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_cell(input ecfl_pkg::ecfl_in_t c, input bit typed,
                           input ecfl_pkg::ecfl_out_t value);
    cell_note_t n;
    n.typed = typed;
    n.value = value;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 50);
    end
    note_q.push_back(n);
    in_valid <= 1'b1;
    in_item <= c;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // Pause the sender until every result is in and the block is quiet
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (dt_exp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [63:0] g, input logic [63:0] x, input logic [63:0] y,
                            input logic [63:0] k);
    logic [63:0] vals[4];
    vals = '{g, x, y, k};
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= ecfl_pkg::CFG_INDEX_W'(i);
      cfg_data <= vals[i][ecfl_pkg::CFG_DATA_W-1:0];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    gamma_sh = g & 64'h3FFFF;
    dx_sh = x & 64'h7FFFFFFF;
    dy_sh = y & 64'h7FFFFFFF;
    courant_sh = k & 64'h1FFFF;
  endtask

  function automatic ecfl_pkg::ecfl_in_t random_cell(input bit last);
    ecfl_pkg::ecfl_in_t c;
    int mode;
    mode = $urandom_range(99);
    c.density = 31'($urandom);
    c.momentum_x = $urandom;
    c.momentum_y = $urandom;
    c.total_energy = 31'($urandom);
    if (mode < 60) begin
      // physical-looking cell: moderate density, small flow, ample energy
      c.density = 31'($urandom_range(32'h0100_0000, 32'h0000_4000));
      c.momentum_x = $signed(32'($urandom_range(32'h0004_0000))) - 32'sh0002_0000;
      c.momentum_y = $signed(32'($urandom_range(32'h0004_0000))) - 32'sh0002_0000;
      c.total_energy = 31'($urandom_range(32'h0100_0000, 32'h0001_0000));
    end else if (mode < 70) begin
      c.density = 31'($urandom_range(3));
    end else if (mode < 78) begin
      c.momentum_x = 0;
      c.momentum_y = 0;
      c.total_energy = 31'($urandom_range(2));
    end
    c.last_cell = last;
    return c;
  endfunction

  task automatic send_reductions(input int count);
    int sent, len;
    ecfl_pkg::ecfl_in_t c;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(9) == 0) ? 1 + $urandom_range(30) : 1 + $urandom_range(7);
      for (int i = 0; i < len; i++) begin
        c = random_cell(i == len - 1);
        if ($urandom_range(19) == 0) c.last_cell = ~c.last_cell;
        send_cell(c, 1'b0, '0);
        sent++;
      end
    end
  endtask

  ecfl_pkg::ecfl_in_t  dir_cells[16];
  bit                  dir_typed[16];
  ecfl_pkg::ecfl_out_t dir_value[16];

  initial begin
    ecfl_pkg::ecfl_out_t none;
    none = '0;
    gamma_sh = {46'd0, ecfl_pkg::GAMMA_RESET};
    dx_sh = {33'd0, ecfl_pkg::SIZE_RESET};
    dy_sh = {33'd0, ecfl_pkg::SIZE_RESET};
    courant_sh = {47'd0, ecfl_pkg::COURANT_RESET};
    dt_min = {32'd0, ecfl_pkg::SAT32};
    clamp_any = 1'b0;

    // Directed cells: density, momentum, energy, last
    dir_cells[0]  = '{31'd65536, 32'sd0, 32'sd0, 31'd0, 1'b1};
    dir_cells[1]  = '{31'h7FFF_FFFF, 32'sh7FFF_FFFF, -32'sh8000_0000, 31'h7FFF_FFFF, 1'b1};
    dir_cells[2]  = '{31'd1, -32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 1'b1};
    dir_cells[3]  = '{31'd0, 32'sd65536, 32'sd65536, 31'd65536, 1'b1};
    dir_cells[4]  = '{31'd65536, 32'sd65536, 32'sd0, 31'd65536, 1'b0};
    dir_cells[5]  = '{31'd65536, 32'sd0, 32'sd0, 31'd655360, 1'b0};
    dir_cells[6]  = '{31'd65536, -32'sd131072, 32'sd65536, 31'd262144, 1'b1};
    dir_cells[7]  = '{31'd65536, 32'sd0, 32'sd0, 31'd1, 1'b1};
    dir_cells[8]  = '{31'd65536, 32'sd0, 32'sd0, 31'h7FFF_FFFF, 1'b1};
    dir_cells[9]  = '{31'h7FFF_FFFF, 32'sd0, 32'sd0, 31'd0, 1'b0};
    dir_cells[10] = '{31'd65536, 32'sd65536, 32'sd65536, 31'd65536, 1'b1};
    dir_cells[11] = '{31'd131072, -32'sd1, -32'sd1, 31'd1000000, 1'b1};
    dir_cells[12] = '{31'h5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 31'h2AAA_AAAA, 1'b0};
    dir_cells[13] = '{31'h2AAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 31'h5555_5555, 1'b1};
    dir_cells[14] = '{31'd3, 32'sd7, -32'sd7, 31'd100, 1'b1};
    dir_cells[15] = '{31'd65536, 32'sd0, 32'sd0, 31'd0, 1'b1};
    foreach (dir_typed[i]) dir_typed[i] = 1'b0;
    // a cell at rest with no energy: zero rate, all-ones dt, clamped pressure
    dir_typed[0] = 1'b1;
    dir_value[0] = '{32'd3865444351, 1'b1};
    dir_typed[15] = 1'b1;
    dir_value[15] = '{32'd3865444351, 1'b1};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_cells[i])
      send_cell(dir_cells[i], dir_typed[i], dir_typed[i] ? dir_value[i] : none);
    drain();

    // Hold the receiver off while the sender keeps offering last cells
    hold_reqs = 1;
    for (int i = 0; i < 4; i++) send_cell(random_cell(1'b1), 1'b0, none);
    send_reductions(100);
    drain();

    set_config(64'd65536, 64'd1, 64'd1, 64'd0);
    send_reductions(150);
    drain();

    set_config(64'd196608, 64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'd65536);
    send_reductions(150);
    drain();

    // Zero sizes act as one; gamma below one clamps every cell
    set_config(64'd0, 64'd0, 64'd0, 64'd32768);
    send_reductions(100);
    drain();

    // A stretch with no idling on either side
    idle_pct = 0;
    set_config(64'd91750, 64'd4096, 64'd1048576, 64'd58982);
    send_reductions(200);
    drain();
    idle_pct = 21;

    for (int k = 0; k < 3; k++) begin
      set_config($urandom_range(196608, 65536), $urandom_range(32'h7FFF_FFFF, 1),
                 $urandom_range(32'h0100_0000, 1), $urandom_range(65536));
      send_reductions(150);
      drain();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
